FILE: rtl/tcte_pkg.sv
// shared types, constants and helpers of the tcp connection table engine
`timescale 1ns / 1ps
package tcte_pkg;

  localparam int CONNECTIONS = 16;
  localparam int CONN_W = $clog2(CONNECTIONS);
  localparam int IDX_W = 5;
  localparam logic [IDX_W-1:0] NO_CONN = IDX_W'(CONNECTIONS);

  localparam logic [2:0] OP_SEGMENT = 3'd0;
  localparam logic [2:0] OP_PASSIVE_OPEN = 3'd1;
  localparam logic [2:0] OP_ACTIVE_OPEN = 3'd2;
  localparam logic [2:0] OP_CLOSE = 3'd3;
  localparam logic [2:0] OP_SEND = 3'd4;
  localparam logic [2:0] OP_CONSUME = 3'd5;

  localparam logic [5:0] F_FIN = 6'h01;
  localparam logic [5:0] F_SYN = 6'h02;
  localparam logic [5:0] F_RST = 6'h04;
  localparam logic [5:0] F_PSH = 6'h08;
  localparam logic [5:0] F_ACK = 6'h10;

  localparam logic [2:0] STAT_DONE = 3'd0;
  localparam logic [2:0] STAT_DROPPED = 3'd1;
  localparam logic [2:0] STAT_FULL = 3'd2;
  localparam logic [2:0] STAT_INVALID = 3'd3;
  localparam logic [2:0] STAT_WND_CLOSED = 3'd4;

  localparam logic CFG_MSS = 1'b0;
  localparam logic CFG_RBS = 1'b1;
  localparam logic [15:0] MSS_RESET = 16'd1460;
  localparam logic [15:0] RBS_RESET = 16'hffff;

  typedef enum logic [3:0] {
    CS_FREE, CS_CLOSED, CS_LISTEN, CS_SYN_SENT, CS_SYN_RCVD, CS_ESTAB,
    CS_FIN_WAIT1, CS_FIN_WAIT2, CS_CLOSING, CS_TIME_WAIT, CS_CLOSE_WAIT, CS_LAST_ACK
  } conn_st_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_READ, S_EX1, S_EX2, S_OUT
  } ctl_state_t;

  typedef struct packed {
    conn_st_t    st;
    logic [31:0] la;
    logic [15:0] lp;
    logic [31:0] fa;
    logic [15:0] fp;
    logic [31:0] snd_nxt;
    logic [31:0] snd_una;
    logic [15:0] snd_wnd;
    logic [31:0] wl1;
    logic [31:0] wl2;
    logic [31:0] iss;
    logic [31:0] rcv_nxt;
    logic [15:0] rcv_wnd;
    logic [31:0] irs;
  } rec_t;

  typedef struct packed {
    logic             kind;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [5:0]       flg;
    logic [15:0]      wnd;
    logic [IDX_W-1:0] idx;
    logic [2:0]       status;
    logic [15:0]      off;
    logic [15:0]      len;
    logic             last;
  } res_t;

  typedef struct packed {
    logic        ack_le_iss;
    logic        ack_gt_nxt;
    logic        una_le_ack;
    logic        una_lt_ack;
    logic        una_gt_iss;
    logic        ack_eq_nxt;
    logic        seq_eq_rn;
    logic        rn_le_seq;
    logic        seq_lt_top;
    logic        rn_le_end;
    logic        end_lt_top;
    logic        wl1_lt_seq;
    logic        wl1_eq_seq;
    logic        wl2_le_ack;
    logic        sl_zero;
    logic [31:0] seq_sl;
    logic [15:0] acc;
    logic [31:0] seq_acc;
    logic [31:0] seq_acc1;
    logic [31:0] seq1;
    logic [31:0] iseq1;
    logic [31:0] sn1;
    logic [15:0] wnd_less_acc;
    logic [15:0] bufd;
    logic [15:0] cap;
    logic [15:0] cons;
  } pre_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic rd;
    logic ex1;
    logic ex2;
    logic out_en;
    logic out_adv;
  } cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic cur_last;
  } sts_t;

  function automatic res_t mk_seg(rec_t r, logic [5:0] flg, logic [15:0] ln,
                                  logic [IDX_W-1:0] ci);
    res_t x;
    x = '0;
    x.kind = 1'b1;
    x.seq = ((flg & F_SYN) != 6'd0) ? r.iss : r.snd_nxt;
    x.ack = r.rcv_nxt;
    x.flg = flg;
    x.wnd = r.rcv_wnd;
    x.idx = ci;
    x.len = ln;
    return x;
  endfunction

  function automatic res_t mk_reply(logic [31:0] sq, logic [31:0] ak, logic [5:0] flg);
    res_t x;
    x = '0;
    x.kind = 1'b1;
    x.seq = sq;
    x.ack = ak;
    x.flg = flg;
    x.idx = NO_CONN;
    return x;
  endfunction

endpackage

FILE: rtl/tcp_connection_table_engine.sv
// top level of the tcp connection table engine
// each transaction passes through the scan, read, two execute and output states; segment and
// open scan all 16 records, the others do not. results then leave one per cycle while result_stall
// is low, up to three. one transaction at a time; segment and open are bound
// by the 16-entry endpoint scan through the single record read port.
// reset: synchronous rst frees every record at once and restores the config registers.
`timescale 1ns / 1ps
module tcp_connection_table_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [2:0]                 op,
  input  logic [31:0]                local_addr,
  input  logic [15:0]                local_port,
  input  logic [31:0]                foreign_addr,
  input  logic [15:0]                foreign_port,
  input  logic [31:0]                seq_num,
  input  logic [31:0]                ack_num,
  input  logic [5:0]                 flags,
  input  logic [15:0]                window,
  input  logic [15:0]                payload_len,
  input  logic [31:0]                initial_seq,
  input  logic [3:0]                 conn_id,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic                       out_kind,
  output logic [31:0]                seg_seq,
  output logic [31:0]                seg_ack,
  output logic [5:0]                 seg_flags,
  output logic [15:0]                seg_window,
  output logic [tcte_pkg::IDX_W-1:0] conn_index,
  output logic [3:0]                 conn_state,
  output logic [2:0]                 status,
  output logic [15:0]                data_offset,
  output logic [15:0]                data_len,
  output logic                       last,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [15:0]                cfg_data
);
  import tcte_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcte_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sts(sts),
    .cmd(cmd)
  );

  tcte_datapath u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .op(op),
    .local_addr(local_addr),
    .local_port(local_port),
    .foreign_addr(foreign_addr),
    .foreign_port(foreign_port),
    .seq_num(seq_num),
    .ack_num(ack_num),
    .flags(flags),
    .window(window),
    .payload_len(payload_len),
    .initial_seq(initial_seq),
    .conn_id(conn_id),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_kind(out_kind),
    .seg_seq(seg_seq),
    .seg_ack(seg_ack),
    .seg_flags(seg_flags),
    .seg_window(seg_window),
    .conn_index(conn_index),
    .conn_state(conn_state),
    .status(status),
    .data_offset(data_offset),
    .data_len(data_len),
    .last(last)
  );

endmodule

FILE: rtl/tcte_ctrl.sv
// controller state machine of the tcp connection table engine
`timescale 1ns / 1ps
module tcte_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  output logic          result_valid,
  input  logic          result_stall,
  input  tcte_pkg::sts_t sts,
  output tcte_pkg::cmd_t cmd
);
  import tcte_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.needs_scan || sts.scan_done) state_next = S_READ;
      end
      S_READ: state_next = S_EX1;
      S_EX1: state_next = S_EX2;
      S_EX2: state_next = S_OUT;
      S_OUT: begin
        if (!result_stall && sts.cur_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    item_stall = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        cmd.load = item_valid;
      end
      S_SCAN: cmd.scan = 1'b1;
      S_READ: cmd.rd = 1'b1;
      S_EX1: cmd.ex1 = 1'b1;
      S_EX2: cmd.ex2 = 1'b1;
      S_OUT: begin
        result_valid = 1'b1;
        cmd.out_en = 1'b1;
        cmd.out_adv = !result_stall;
      end
      default: item_stall = 1'b1;
    endcase
  end

  a_ex2_after_ex1: assert property (@(posedge clk) disable iff (rst)
    state == S_EX2 |-> $past(state) == S_EX1)
    else $error("execute stage entered out of order");

endmodule

FILE: rtl/tcte_datapath.sv
// datapath of the tcp connection table engine: record table, scan, rules, result buffer
`timescale 1ns / 1ps
module tcte_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tcte_pkg::cmd_t                cmd,
  output tcte_pkg::sts_t                sts,
  input  logic [2:0]                    op,
  input  logic [31:0]                   local_addr,
  input  logic [15:0]                   local_port,
  input  logic [31:0]                   foreign_addr,
  input  logic [15:0]                   foreign_port,
  input  logic [31:0]                   seq_num,
  input  logic [31:0]                   ack_num,
  input  logic [5:0]                    flags,
  input  logic [15:0]                   window,
  input  logic [15:0]                   payload_len,
  input  logic [31:0]                   initial_seq,
  input  logic [3:0]                    conn_id,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_data,
  output logic                          out_kind,
  output logic [31:0]                   seg_seq,
  output logic [31:0]                   seg_ack,
  output logic [5:0]                    seg_flags,
  output logic [15:0]                   seg_window,
  output logic [tcte_pkg::IDX_W-1:0]    conn_index,
  output logic [3:0]                    conn_state,
  output logic [2:0]                    status,
  output logic [15:0]                   data_offset,
  output logic [15:0]                   data_len,
  output logic                          last
);
  import tcte_pkg::*;

  // configuration
  logic [15:0] mss, rbs;
  always_ff @(posedge clk) begin
    if (rst) begin
      mss <= MSS_RESET;
      rbs <= RBS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MSS) mss <= cfg_data;
      else rbs <= cfg_data;
    end
  end

  // captured transaction
  logic [2:0]  op_q;
  logic [31:0] la_q, fa_q, seq_q, ack_q, iseq_q;
  logic [15:0] lp_q, fp_q, wnd_q, len_q;
  logic [5:0]  flg_q;
  logic [3:0]  id_q;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= op;
      la_q <= local_addr;
      lp_q <= local_port;
      fa_q <= foreign_addr;
      fp_q <= foreign_port;
      seq_q <= seq_num;
      ack_q <= ack_num;
      flg_q <= flags;
      wnd_q <= window;
      len_q <= payload_len;
      iseq_q <= initial_seq;
      id_q <= conn_id;
    end
  end

  // record table
  rec_t                   tbl [CONNECTIONS];
  logic [CONNECTIONS-1:0] vld;
  logic [CONN_W-1:0]      rd_a;
  rec_t                   rd_q;
  logic                   wr_en;
  logic [CONN_W-1:0]      wr_a;
  rec_t                   wr_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_a] <= (wr_d.st != CS_FREE);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) tbl[wr_a] <= wr_d;
    rd_q <= vld[rd_a] ? tbl[rd_a] : '0;
  end

  // endpoint scan
  logic [CONN_W:0]   cnt;
  logic              scan_v;
  logic [CONN_W-1:0] scan_a;
  logic              ex_v, wild_v, free_v;
  logic [CONN_W-1:0] ex_idx, wild_idx, free_idx;
  logic              hit;

  assign hit = (rd_q.st != CS_FREE) && (rd_q.la == 32'd0 || rd_q.la == la_q) &&
               (rd_q.lp == lp_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      scan_v <= 1'b0;
      ex_v <= 1'b0;
      wild_v <= 1'b0;
      free_v <= 1'b0;
    end else if (cmd.load) begin
      cnt <= '0;
      scan_v <= 1'b0;
      ex_v <= 1'b0;
      wild_v <= 1'b0;
      free_v <= 1'b0;
    end else if (cmd.scan) begin
      scan_v <= (cnt < (CONN_W+1)'(CONNECTIONS));
      if (cnt < (CONN_W+1)'(CONNECTIONS)) cnt <= cnt + 1'b1;
      if (scan_v) begin
        if (rd_q.st == CS_FREE && !free_v) begin
          free_v <= 1'b1;
          free_idx <= scan_a;
        end
        if (hit && !ex_v) begin
          if (rd_q.fa == fa_q && rd_q.fp == fp_q) begin
            ex_v <= 1'b1;
            ex_idx <= scan_a;
          end else if (rd_q.st == CS_LISTEN && rd_q.fa == 32'd0 && rd_q.fp == 16'd0) begin
            wild_v <= 1'b1;
            wild_idx <= scan_a;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_a <= cnt[CONN_W-1:0];
  end

  assign sts.needs_scan = (op_q == OP_SEGMENT) || (op_q == OP_PASSIVE_OPEN) ||
                          (op_q == OP_ACTIVE_OPEN);
  assign sts.scan_done = (cnt == (CONN_W+1)'(CONNECTIONS)) && !scan_v;

  logic [IDX_W-1:0] c_sel, c_q;
  always_comb begin
    c_sel = NO_CONN;
    case (op_q)
      OP_SEGMENT: begin
        if (ex_v) c_sel = IDX_W'(ex_idx);
        else if (wild_v) c_sel = IDX_W'(wild_idx);
      end
      OP_PASSIVE_OPEN, OP_ACTIVE_OPEN: begin
        if (free_v) c_sel = IDX_W'(free_idx);
      end
      OP_CLOSE, OP_SEND, OP_CONSUME: begin
        if (IDX_W'(id_q) < IDX_W'(CONNECTIONS)) c_sel = IDX_W'(id_q);
      end
      default: c_sel = NO_CONN;
    endcase
  end

  assign rd_a = cmd.scan ? cnt[CONN_W-1:0] : c_sel[CONN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.rd) c_q <= c_sel;
  end

  // precompute stage
  rec_t        rec_q;
  pre_t        pre_d, pre_q;
  logic [16:0] seglen;
  logic [31:0] top, seg_end, inflight;
  always_comb begin
    seglen = {1'b0, len_q} + 17'((flg_q & F_SYN) != 6'd0) + 17'((flg_q & F_FIN) != 6'd0);
    top = rd_q.rcv_nxt + {16'd0, rd_q.rcv_wnd};
    seg_end = seq_q + {15'd0, seglen} - 32'd1;
    inflight = rd_q.snd_nxt - rd_q.snd_una;
    pre_d.ack_le_iss = ack_q <= rd_q.iss;
    pre_d.ack_gt_nxt = ack_q > rd_q.snd_nxt;
    pre_d.una_le_ack = rd_q.snd_una <= ack_q;
    pre_d.una_lt_ack = rd_q.snd_una < ack_q;
    pre_d.una_gt_iss = rd_q.snd_una > rd_q.iss;
    pre_d.ack_eq_nxt = ack_q == rd_q.snd_nxt;
    pre_d.seq_eq_rn = seq_q == rd_q.rcv_nxt;
    pre_d.rn_le_seq = rd_q.rcv_nxt <= seq_q;
    pre_d.seq_lt_top = seq_q < top;
    pre_d.rn_le_end = rd_q.rcv_nxt <= seg_end;
    pre_d.end_lt_top = seg_end < top;
    pre_d.wl1_lt_seq = rd_q.wl1 < seq_q;
    pre_d.wl1_eq_seq = rd_q.wl1 == seq_q;
    pre_d.wl2_le_ack = rd_q.wl2 <= ack_q;
    pre_d.sl_zero = seglen == 17'd0;
    pre_d.seq_sl = seq_q + {15'd0, seglen};
    pre_d.acc = (len_q < rd_q.rcv_wnd) ? len_q : rd_q.rcv_wnd;
    pre_d.seq_acc = seq_q + {16'd0, pre_d.acc};
    pre_d.seq_acc1 = seq_q + {16'd0, pre_d.acc} + 32'd1;
    pre_d.seq1 = seq_q + 32'd1;
    pre_d.iseq1 = iseq_q + 32'd1;
    pre_d.sn1 = rd_q.snd_nxt + 32'd1;
    pre_d.wnd_less_acc = rd_q.rcv_wnd - pre_d.acc;
    pre_d.bufd = (rbs > rd_q.rcv_wnd) ? (rbs - rd_q.rcv_wnd) : 16'd0;
    pre_d.cap = ({16'd0, rd_q.snd_wnd} > inflight) ?
                (rd_q.snd_wnd - inflight[15:0]) : 16'd0;
    pre_d.cons = (len_q < pre_d.bufd) ? len_q : pre_d.bufd;
  end

  always_ff @(posedge clk) begin
    if (cmd.ex1) begin
      rec_q <= rd_q;
      pre_q <= pre_d;
    end
  end

  // rule stage
  rec_t             r;
  conn_st_t         st;
  logic [IDX_W-1:0] c;
  logic [2:0]       stat;
  logic [1:0]       nseg;
  res_t             segs [2];
  res_t             sres;
  logic [15:0]      off, dlen, s, mss_e;
  logic             done, ok, taken;

  always_comb begin
    r = rec_q;
    st = rec_q.st;
    c = c_q;
    stat = STAT_DONE;
    nseg = 2'd0;
    segs[0] = '0;
    segs[1] = '0;
    off = 16'd0;
    dlen = 16'd0;
    s = 16'd0;
    mss_e = (mss == 16'd0) ? 16'd1 : mss;
    done = 1'b0;
    ok = 1'b0;
    taken = 1'b0;
    case (op_q)
      OP_SEGMENT: begin
        if (c == NO_CONN || st == CS_CLOSED) begin
          stat = STAT_DROPPED;
          if ((flg_q & F_RST) == 6'd0) begin
            if ((flg_q & F_ACK) == 6'd0) segs[0] = mk_reply(32'd0, pre_q.seq_sl, F_RST | F_ACK);
            else segs[0] = mk_reply(ack_q, 32'd0, F_RST);
            nseg = 2'd1;
          end
        end else if (st == CS_LISTEN) begin
          stat = STAT_DROPPED;
          if ((flg_q & F_RST) != 6'd0) begin
            stat = STAT_DROPPED;
          end else if ((flg_q & F_ACK) != 6'd0) begin
            segs[0] = mk_reply(ack_q, 32'd0, F_RST);
            nseg = 2'd1;
          end else if ((flg_q & F_SYN) != 6'd0) begin
            stat = STAT_DONE;
            r.la = la_q;
            r.lp = lp_q;
            r.fa = fa_q;
            r.fp = fp_q;
            r.rcv_wnd = rbs;
            r.rcv_nxt = pre_q.seq1;
            r.irs = seq_q;
            r.iss = iseq_q;
            segs[0] = mk_seg(r, F_SYN | F_ACK, 16'd0, c);
            nseg = 2'd1;
            r.snd_nxt = pre_q.iseq1;
            r.snd_una = iseq_q;
            r.st = CS_SYN_RCVD;
          end
        end else if (st == CS_SYN_SENT) begin
          if ((flg_q & F_ACK) != 6'd0 && (pre_q.ack_le_iss || pre_q.ack_gt_nxt)) begin
            stat = STAT_DROPPED;
            segs[0] = mk_reply(ack_q, 32'd0, F_RST);
            nseg = 2'd1;
          end else if ((flg_q & F_SYN) == 6'd0) begin
            stat = STAT_DROPPED;
          end else begin
            ok = ((flg_q & F_ACK) != 6'd0) && pre_q.una_le_ack;
            r.rcv_nxt = pre_q.seq1;
            r.irs = seq_q;
            if (ok) r.snd_una = ack_q;
            if (ok ? !pre_q.ack_le_iss : pre_q.una_gt_iss) begin
              r.st = CS_ESTAB;
              segs[0] = mk_seg(r, F_ACK, 16'd0, c);
              r.snd_wnd = wnd_q;
              r.wl1 = seq_q;
              r.wl2 = ack_q;
            end else begin
              r.st = CS_SYN_RCVD;
              segs[0] = mk_seg(r, F_SYN | F_ACK, 16'd0, c);
            end
            nseg = 2'd1;
          end
        end else begin
          if (st inside {CS_SYN_RCVD, CS_ESTAB, CS_FIN_WAIT1, CS_FIN_WAIT2,
                         CS_CLOSE_WAIT, CS_LAST_ACK}) begin
            if (pre_q.sl_zero) begin
              if (r.rcv_wnd == 16'd0) ok = pre_q.seq_eq_rn;
              else ok = pre_q.rn_le_seq && pre_q.seq_lt_top;
            end else begin
              ok = (r.rcv_wnd != 16'd0) &&
                   ((pre_q.rn_le_seq && pre_q.seq_lt_top) ||
                    (pre_q.rn_le_end && pre_q.end_lt_top));
            end
            if (!ok) begin
              stat = STAT_DROPPED;
              done = 1'b1;
              if ((flg_q & F_RST) == 6'd0) begin
                segs[0] = mk_seg(r, F_ACK, 16'd0, c);
                nseg = 2'd1;
              end
            end
          end
          if (!done && (flg_q & F_ACK) == 6'd0) begin
            stat = STAT_DROPPED;
            done = 1'b1;
          end
          if (!done && st == CS_SYN_RCVD) begin
            if (pre_q.una_le_ack && !pre_q.ack_gt_nxt) begin
              r.st = CS_ESTAB;
              st = CS_ESTAB;
            end else begin
              segs[0] = mk_reply(ack_q, 32'd0, F_RST);
              nseg = 2'd1;
              stat = STAT_DROPPED;
              done = 1'b1;
            end
          end
          if (!done) begin
            if (st inside {CS_ESTAB, CS_FIN_WAIT1, CS_FIN_WAIT2, CS_CLOSE_WAIT,
                           CS_CLOSING}) begin
              if (pre_q.una_lt_ack && !pre_q.ack_gt_nxt) begin
                r.snd_una = ack_q;
                if (pre_q.wl1_lt_seq || (pre_q.wl1_eq_seq && pre_q.wl2_le_ack)) begin
                  r.snd_wnd = wnd_q;
                  r.wl1 = seq_q;
                  r.wl2 = ack_q;
                end
              end else if (pre_q.ack_gt_nxt) begin
                segs[0] = mk_seg(r, F_ACK, 16'd0, c);
                nseg = 2'd1;
                stat = STAT_DROPPED;
                done = 1'b1;
              end
              if (!done) begin
                if (st == CS_FIN_WAIT1 && pre_q.ack_eq_nxt) begin
                  r.st = CS_FIN_WAIT2;
                  st = CS_FIN_WAIT2;
                end else if (st == CS_CLOSING && pre_q.ack_eq_nxt) begin
                  r.st = CS_TIME_WAIT;
                  st = CS_TIME_WAIT;
                end
              end
            end else if (st == CS_LAST_ACK) begin
              if (pre_q.ack_eq_nxt) r = '0;
              done = 1'b1;
            end
          end
          if (!done) begin
            if ((st inside {CS_ESTAB, CS_FIN_WAIT1, CS_FIN_WAIT2}) && len_q != 16'd0 &&
                pre_q.acc != 16'd0) begin
              taken = 1'b1;
              off = pre_q.bufd;
              dlen = pre_q.acc;
              r.rcv_nxt = pre_q.seq_acc;
              r.rcv_wnd = pre_q.wnd_less_acc;
              segs[nseg[0]] = mk_seg(r, F_ACK, 16'd0, c);
              nseg = nseg + 2'd1;
            end
            if ((flg_q & F_FIN) != 6'd0) begin
              r.rcv_nxt = taken ? pre_q.seq_acc1 : pre_q.seq1;
              segs[nseg[0]] = mk_seg(r, F_ACK, 16'd0, c);
              nseg = nseg + 2'd1;
              if (st == CS_SYN_RCVD || st == CS_ESTAB) r.st = CS_CLOSE_WAIT;
              else if (st == CS_FIN_WAIT1)
                r.st = pre_q.ack_eq_nxt ? CS_TIME_WAIT : CS_CLOSING;
              else if (st == CS_FIN_WAIT2) r.st = CS_TIME_WAIT;
            end
          end
        end
      end
      OP_PASSIVE_OPEN, OP_ACTIVE_OPEN: begin
        if (c == NO_CONN) begin
          stat = STAT_FULL;
        end else begin
          r.la = la_q;
          r.lp = lp_q;
          r.fa = fa_q;
          r.fp = fp_q;
          if (op_q == OP_PASSIVE_OPEN) begin
            r.st = CS_LISTEN;
          end else begin
            r.rcv_wnd = rbs;
            r.iss = iseq_q;
            segs[0] = mk_seg(r, F_SYN, 16'd0, c);
            nseg = 2'd1;
            r.snd_nxt = pre_q.iseq1;
            r.snd_una = iseq_q;
            r.st = CS_SYN_SENT;
          end
        end
      end
      OP_CLOSE, OP_SEND, OP_CONSUME: begin
        if (c == NO_CONN || st == CS_FREE) begin
          stat = STAT_INVALID;
          c = NO_CONN;
        end else if (op_q == OP_CLOSE) begin
          if (st == CS_ESTAB || st == CS_CLOSE_WAIT) begin
            segs[0] = mk_seg(r, F_ACK | F_FIN, 16'd0, c);
            nseg = 2'd1;
            r.snd_nxt = pre_q.sn1;
            r.st = (st == CS_ESTAB) ? CS_FIN_WAIT1 : CS_LAST_ACK;
          end else if (st == CS_LISTEN || st == CS_SYN_SENT) begin
            r = '0;
          end else begin
            stat = STAT_INVALID;
          end
        end else if (op_q == OP_SEND) begin
          if (st == CS_ESTAB || st == CS_CLOSE_WAIT) begin
            if (len_q != 16'd0) begin
              if (pre_q.cap == 16'd0) begin
                stat = STAT_WND_CLOSED;
              end else begin
                s = len_q;
                if (pre_q.cap < s) s = pre_q.cap;
                if (mss_e < s) s = mss_e;
                segs[0] = mk_seg(r, F_PSH | F_ACK, s, c);
                nseg = 2'd1;
                r.snd_nxt = r.snd_nxt + {16'd0, s};
                dlen = s;
              end
            end
          end else begin
            stat = STAT_INVALID;
          end
        end else begin
          if (st == CS_ESTAB || st == CS_CLOSE_WAIT) begin
            r.rcv_wnd = r.rcv_wnd + pre_q.cons;
            dlen = pre_q.cons;
          end else begin
            stat = STAT_INVALID;
          end
        end
      end
      default: stat = STAT_DROPPED;
    endcase
    sres = '0;
    sres.idx = c;
    sres.status = stat;
    sres.off = off;
    sres.len = dlen;
    sres.last = 1'b1;
  end

  assign wr_en = cmd.ex2 && (c != NO_CONN);
  assign wr_a = c[CONN_W-1:0];
  assign wr_d = r;

  // result buffer
  res_t       res [3];
  logic [1:0] n_res, optr;
  conn_st_t   st_fin;
  res_t       cur;

  always_ff @(posedge clk) begin
    if (cmd.ex2) begin
      res[0] <= (nseg != 2'd0) ? segs[0] : sres;
      res[1] <= (nseg == 2'd2) ? segs[1] : sres;
      res[2] <= sres;
      n_res <= nseg + 2'd1;
      st_fin <= (c != NO_CONN) ? r.st : CS_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      optr <= 2'd0;
    end else if (cmd.ex2) begin
      optr <= 2'd0;
    end else if (cmd.out_adv) begin
      optr <= optr + 2'd1;
    end
  end

  assign cur = (optr == 2'd0) ? res[0] : ((optr == 2'd1) ? res[1] : res[2]);
  assign sts.cur_last = cur.last;

  assign out_kind = cur.kind;
  assign seg_seq = cur.seq;
  assign seg_ack = cur.ack;
  assign seg_flags = cur.flg;
  assign seg_window = cur.wnd;
  assign conn_index = cur.idx;
  assign conn_state = st_fin;
  assign status = cur.status;
  assign data_offset = cur.off;
  assign data_len = cur.len;
  assign last = cur.last;

  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.ex2 |=> n_res != 2'd0)
    else $error("no results after execute");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.out_en |-> optr < n_res)
    else $error("result pointer beyond buffer");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    cmd.out_en && cur.last |-> optr == n_res - 2'd1)
    else $error("final result not at buffer end");

endmodule
